// ===== design/crc16_frame_encoder_core_assert.svh =====
// ----------------------------------------------------------------------------
// crc16_frame_encoder_core assertion macros
// Concurrent assertion wrappers used by the frame encoder modules. They expand
// to nothing when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef CRC16_FRAME_ENCODER_CORE_ASSERT_SVH
`define CRC16_FRAME_ENCODER_CORE_ASSERT_SVH

`ifndef SYNTHESIS

// Checked on every rising clk edge outside reset.
`define C16FE_ASSERT(name, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checked on every rising clk edge, reset included.
`define C16FE_ASSERT_ALWAYS(name, prop, msg) \
	name: assert property (@(posedge clk) prop) else $error(msg);

`else

`define C16FE_ASSERT(name, prop, msg)
`define C16FE_ASSERT_ALWAYS(name, prop, msg)

`endif

`endif

// ===== design/crc16fe_pkg.sv =====
// ----------------------------------------------------------------------------
// crc16fe_pkg
// Shared types, constants and the byte-wise CRC-16/MODBUS update function.
// ----------------------------------------------------------------------------
`default_nettype none

package crc16fe_pkg;

	localparam int LEN_W           = 6;
	localparam int STEP_W          = 3;
	localparam int MAX_PAYLOAD_DEF = 57;
	localparam int CMDQ_DEPTH_DEF  = 4;

	localparam logic [7:0]  SYNC_A   = 8'hAA;
	localparam logic [7:0]  SYNC_B   = 8'h55;
	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'hA001;

	localparam logic REQ_HEADER  = 1'b0;
	localparam logic REQ_PAYLOAD = 1'b1;

	typedef struct packed {
		logic             req_type;
		logic [7:0]       frame_address;
		logic [7:0]       function_code;
		logic [LEN_W-1:0] payload_length;
		logic [7:0]       payload_byte;
	} in_item_t;

	typedef struct packed {
		logic [7:0] tx_byte;
		logic       run_end;
		logic       frame_end;
		logic       error;
	} out_item_t;

	typedef enum logic [1:0] {
		CMD_ERR = 2'd0,
		CMD_HDR = 2'd1,
		CMD_PAY = 2'd2
	} cmd_kind_t;

	// One classified item as handed from the front end to the sequencer.
	typedef struct packed {
		cmd_kind_t        kind;
		logic [7:0]       byte_a;    // address on a header, data on a payload
		logic [7:0]       byte_b;    // function code on a header
		logic [LEN_W-1:0] len;
		logic             crc_tail;  // this item closes the frame with the CRC
	} cmd_t;

	// Reflected CRC-16 update over one byte, least significant bit first.
	function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

`default_nettype wire

// ===== design/crc16fe_front.sv =====
// ----------------------------------------------------------------------------
// crc16fe_front
// Accepts input beats, tracks the open frame and turns each beat into one
// sequencer command.
// ----------------------------------------------------------------------------
`default_nettype none

`include "crc16_frame_encoder_core_assert.svh"

module crc16fe_front
	import crc16fe_pkg::*;
#(
	parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     push,
	input  wire in_item_t item,
	input  wire logic     full,
	output logic          cmd_push,
	output cmd_t          cmd
);

	logic             in_frame_q;
	logic [LEN_W-1:0] left_q;
	logic             accept;
	logic             too_long;

	assign accept   = push && !full;
	assign cmd_push = accept;
	assign too_long = item.payload_length > LEN_W'(MAX_PAYLOAD);

	always_comb begin
		cmd          = '0;
		cmd.kind     = CMD_ERR;
		if (item.req_type == REQ_HEADER) begin
			if (!too_long) begin
				cmd.kind     = CMD_HDR;
				cmd.byte_a   = item.frame_address;
				cmd.byte_b   = item.function_code;
				cmd.len      = item.payload_length;
				cmd.crc_tail = item.payload_length == '0;
			end
		end else if (in_frame_q) begin
			cmd.kind     = CMD_PAY;
			cmd.byte_a   = item.payload_byte;
			cmd.crc_tail = left_q == LEN_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q <= 1'b0;
			left_q     <= '0;
		end else if (accept) begin
			case (cmd.kind)
				CMD_HDR: begin
					in_frame_q <= item.payload_length != '0;
					left_q     <= item.payload_length;
				end
				CMD_PAY: begin
					in_frame_q <= left_q != LEN_W'(1);
					left_q     <= left_q - LEN_W'(1);
				end
				default: begin
				end
			endcase
		end
	end

	`C16FE_ASSERT(a_frame_count, in_frame_q == (left_q != '0), "frame flag and byte count disagree")

endmodule

`default_nettype wire

// ===== design/crc16fe_cmdq.sv =====
// ----------------------------------------------------------------------------
// crc16fe_cmdq
// Small command queue between the front end and the byte sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

`include "crc16_frame_encoder_core_assert.svh"

module crc16fe_cmdq
	import crc16fe_pkg::*;
#(
	parameter int DEPTH = CMDQ_DEPTH_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic wr,
	input  wire cmd_t wr_data,
	output logic      full,
	input  wire logic rd,
	output cmd_t      rd_data,
	output logic      empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	cmd_t             slot_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_wr;
	logic             do_rd;

	assign full    = cnt_q == CNT_W'(DEPTH);
	assign empty   = cnt_q == '0;
	assign do_wr   = wr && !full;
	assign do_rd   = rd && !empty;
	assign rd_data = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			slot_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

	`C16FE_ASSERT_ALWAYS(a_cnt_bound, cnt_q <= CNT_W'(DEPTH), "queue count above depth")

endmodule

`default_nettype wire

// ===== design/crc16fe_back.sv =====
// ----------------------------------------------------------------------------
// crc16fe_back
// Byte sequencer: expands each command into output bytes, one per cycle while
// unstalled, keeps the running CRC and holds the result in an output register.
// ----------------------------------------------------------------------------
`default_nettype none

`include "crc16_frame_encoder_core_assert.svh"

module crc16fe_back
	import crc16fe_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire cmd_t q_data,
	input  wire logic q_empty,
	output logic      q_pop,
	output out_item_t result,
	output logic      empty,
	input  wire logic pop
);

	// Header byte positions.
	localparam logic [STEP_W-1:0] HDR_SYNC_A = 3'd0;
	localparam logic [STEP_W-1:0] HDR_SYNC_B = 3'd1;
	localparam logic [STEP_W-1:0] HDR_ADDR   = 3'd2;
	localparam logic [STEP_W-1:0] HDR_FUNC   = 3'd3;
	localparam logic [STEP_W-1:0] HDR_LEN    = 3'd4;
	localparam logic [STEP_W-1:0] HDR_CRC_LO = 3'd5;
	localparam logic [STEP_W-1:0] HDR_CRC_HI = 3'd6;
	// Payload byte positions.
	localparam logic [STEP_W-1:0] PAY_DATA   = 3'd0;
	localparam logic [STEP_W-1:0] PAY_CRC_LO = 3'd1;
	localparam logic [STEP_W-1:0] PAY_CRC_HI = 3'd2;

	cmd_t              cur_q;
	logic              cur_valid_q;
	logic [STEP_W-1:0] step_q;
	logic [15:0]       crc_q;
	out_item_t         out_q;
	logic              out_valid_q;

	out_item_t         nxt;
	logic              fold;
	logic              last;
	logic              advance;
	logic              load;
	logic [15:0]       crc_base;

	assign advance = cur_valid_q && (!out_valid_q || pop);
	assign load    = !cur_valid_q || (advance && last);
	assign q_pop   = load && !q_empty;
	assign result  = out_q;
	assign empty   = !out_valid_q;

	always_comb begin
		nxt  = '0;
		fold = 1'b0;
		last = 1'b0;
		case (cur_q.kind)
			CMD_HDR: begin
				case (step_q)
					HDR_SYNC_A: begin
						nxt.tx_byte = SYNC_A;
						fold        = 1'b1;
					end
					HDR_SYNC_B: begin
						nxt.tx_byte = SYNC_B;
						fold        = 1'b1;
					end
					HDR_ADDR: begin
						nxt.tx_byte = cur_q.byte_a;
						fold        = 1'b1;
					end
					HDR_FUNC: begin
						nxt.tx_byte = cur_q.byte_b;
						fold        = 1'b1;
					end
					HDR_LEN: begin
						nxt.tx_byte = {{(8 - LEN_W){1'b0}}, cur_q.len};
						nxt.run_end = !cur_q.crc_tail;
						fold        = 1'b1;
						last        = !cur_q.crc_tail;
					end
					HDR_CRC_LO: begin
						nxt.tx_byte = crc_q[7:0];
					end
					HDR_CRC_HI: begin
						nxt.tx_byte   = crc_q[15:8];
						nxt.run_end   = 1'b1;
						nxt.frame_end = 1'b1;
						last          = 1'b1;
					end
					default: begin
						last = 1'b1;
					end
				endcase
			end
			CMD_PAY: begin
				case (step_q)
					PAY_DATA: begin
						nxt.tx_byte = cur_q.byte_a;
						nxt.run_end = !cur_q.crc_tail;
						fold        = 1'b1;
						last        = !cur_q.crc_tail;
					end
					PAY_CRC_LO: begin
						nxt.tx_byte = crc_q[7:0];
					end
					PAY_CRC_HI: begin
						nxt.tx_byte   = crc_q[15:8];
						nxt.run_end   = 1'b1;
						nxt.frame_end = 1'b1;
						last          = 1'b1;
					end
					default: begin
						last = 1'b1;
					end
				endcase
			end
			CMD_ERR: begin
				nxt.run_end = 1'b1;
				nxt.error   = 1'b1;
				last        = 1'b1;
			end
			default: begin
				nxt.run_end = 1'b1;
				nxt.error   = 1'b1;
				last        = 1'b1;
			end
		endcase
	end

	// A header restarts the checksum from the initial value.
	assign crc_base = (cur_q.kind == CMD_HDR && step_q == HDR_SYNC_A) ? CRC_INIT : crc_q;

	always_ff @(posedge clk) begin
		if (load) begin
			cur_q <= q_data;
		end
		if (advance) begin
			out_q <= nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			step_q      <= '0;
			crc_q       <= CRC_INIT;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				cur_valid_q <= !q_empty;
				step_q      <= '0;
			end else if (advance) begin
				step_q <= step_q + STEP_W'(1);
			end
			if (advance && fold) begin
				crc_q <= crc_update(crc_base, nxt.tx_byte);
			end else if (advance && nxt.frame_end) begin
				crc_q <= CRC_INIT;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	`C16FE_ASSERT(a_fend_run, out_valid_q && out_q.frame_end |-> out_q.run_end, "frame end without run end")
	`C16FE_ASSERT(a_err_clean, out_valid_q && out_q.error |-> out_q.tx_byte == 8'h00 && !out_q.frame_end, "error beat carries data")
	`C16FE_ASSERT(a_crc_rearm, advance && nxt.frame_end |=> crc_q == CRC_INIT, "checksum not reset after frame")

endmodule

`default_nettype wire

// ===== design/crc16_frame_encoder_core.sv =====
// ----------------------------------------------------------------------------
// crc16_frame_encoder_core
// Frame encoder: sync bytes, header, payload and CRC-16/MODBUS trailer as a
// stream of byte results.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake              Beat type    Contents
//  -------   ---------------------  -----------  ---------------------------------
//  input     push / full            in_item_t    header or payload byte request
//  output    empty / pop            out_item_t   frame byte, run/frame end, error
//
// The sequencer sends one output beat per cycle while the output is not stalled;
// a header gives five beats (seven when a zero length adds the CRC), a payload
// byte one beat (three when it is the last one) and a rejected item one beat.
// An input beat is taken in the cycle it arrives while the command queue has room;
// the queue depth sets how far the input can run ahead of the byte sequencer.
// The asynchronous reset clears all control state and sets the CRC to all ones;
// there is no clearing pass.
// A stalled output holds its beat and the sequencer waits; the input keeps
// filling the queue until it is full.
//
`default_nettype none

module crc16_frame_encoder_core
	import crc16fe_pkg::*;
#(
	parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF,  // longest legal payload, 1 to 63
	parameter int CMDQ_DEPTH  = CMDQ_DEPTH_DEF    // command queue entries, at least 2
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     push,
	output logic          full,
	input  wire in_item_t item,
	output logic          empty,
	input  wire logic     pop,
	output out_item_t     result
);

	// Front end to queue.
	logic cmd_push;
	cmd_t cmd;

	// Queue to sequencer.
	cmd_t q_data;
	logic q_empty;
	logic q_pop;

	// The front end classifies each beat and keeps the frame bookkeeping, so it
	// knows at acceptance time whether a payload byte closes the frame.
	crc16fe_front #(
		.MAX_PAYLOAD(MAX_PAYLOAD)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.item    (item),
		.full    (full),
		.cmd_push(cmd_push),
		.cmd     (cmd)
	);

	// Full of the queue is the full seen by the producer.
	crc16fe_cmdq #(
		.DEPTH(CMDQ_DEPTH)
	) u_cmdq (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (cmd_push),
		.wr_data(cmd),
		.full   (full),
		.rd     (q_pop),
		.rd_data(q_data),
		.empty  (q_empty)
	);

	// The sequencer owns the running CRC, since it sees bytes in frame order.
	crc16fe_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.q_data (q_data),
		.q_empty(q_empty),
		.q_pop  (q_pop),
		.result (result),
		.empty  (empty),
		.pop    (pop)
	);

endmodule

`default_nettype wire

// ===== sim/crc16_frame_encoder_core_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// crc16_frame_encoder_core_test
// Self-checking bench for the CRC-16/MODBUS frame encoder. Header and payload
// beats go in through the push/full side, and a local model of the framing and
// the checksum predicts every output byte. Each byte popped from the output side
// is compared field by field with the oldest prediction. Both sides stall in
// random bursts, except in the closing stretch of the run.
// ----------------------------------------------------------------------------

module crc16_frame_encoder_core_test;
	import crc16fe_pkg::*;

	localparam int MAX_LEN     = MAX_PAYLOAD_DEF;
	localparam int CYCLE_LIMIT = 500000;
	localparam int RANDOM_ITEMS = 250;

	logic      clk;
	logic      arst_n;
	logic      push;
	logic      full;
	in_item_t  item;
	logic      empty;
	logic      pop;
	out_item_t result;

	crc16_frame_encoder_core #(
		.MAX_PAYLOAD(MAX_LEN)
	) dut (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.full  (full),
		.item  (item),
		.empty (empty),
		.pop   (pop),
		.result(result)
	);

	// Free-running clock with an 8 ns period.
	initial clk = 1'b0;
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Model state: the checksum of the open frame, the payload bytes still owed
	// and whether a frame is open at all.
	logic [15:0] frame_crc;
	logic [5:0]  bytes_remaining;
	logic        frame_open;

	// Output bytes predicted but not yet popped, oldest first.
	out_item_t frame_bytes_due[$];

	int error_count;
	int items_sent;
	int beats_checked;
	int cycle_count;
	int big_frames_left;
	bit quiet;          // set for the closing stretch: no stalls on either side
	int pop_hold;

	// ------------------------------------------------------------------------
	// Prediction
	// ------------------------------------------------------------------------

	// Reflected CRC-16 over one byte, least significant bit first.
	function automatic logic [15:0] crc16_fold(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] acc;
		acc = crc ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			acc = acc[0] ? ((acc >> 1) ^ CRC_POLY) : (acc >> 1);
		end
		return acc;
	endfunction

	// A frame byte goes out and is folded into the running checksum.
	function void queue_frame_byte(input logic [7:0] b, input logic last_of_item);
		out_item_t beat;
		beat.tx_byte   = b;
		beat.run_end   = last_of_item;
		beat.frame_end = 1'b0;
		beat.error     = 1'b0;
		frame_crc = crc16_fold(frame_crc, b);
		frame_bytes_due.push_back(beat);
	endfunction

	// The checksum closes the frame, low byte first, and the model returns to idle.
	function void queue_crc_tail();
		out_item_t beat;
		beat.tx_byte   = frame_crc[7:0];
		beat.run_end   = 1'b0;
		beat.frame_end = 1'b0;
		beat.error     = 1'b0;
		frame_bytes_due.push_back(beat);
		beat.tx_byte   = frame_crc[15:8];
		beat.run_end   = 1'b1;
		beat.frame_end = 1'b1;
		frame_bytes_due.push_back(beat);
		frame_crc       = CRC_INIT;
		frame_open      = 1'b0;
		bytes_remaining = '0;
	endfunction

	// A rejected item gives a single error byte and leaves the state alone.
	function void queue_reject();
		out_item_t beat;
		beat.tx_byte   = 8'h00;
		beat.run_end   = 1'b1;
		beat.frame_end = 1'b0;
		beat.error     = 1'b1;
		frame_bytes_due.push_back(beat);
	endfunction

	// Works out every output byte that one accepted input beat causes.
	function void encode_item(input in_item_t it);
		if (it.req_type == REQ_HEADER) begin
			if (it.payload_length > MAX_LEN) begin
				queue_reject();
			end else begin
				// A header always restarts the checksum, even inside an open frame.
				frame_crc = CRC_INIT;
				queue_frame_byte(SYNC_A, 1'b0);
				queue_frame_byte(SYNC_B, 1'b0);
				queue_frame_byte(it.frame_address, 1'b0);
				queue_frame_byte(it.function_code, 1'b0);
				queue_frame_byte({2'b00, it.payload_length}, it.payload_length != 0);
				if (it.payload_length == 0) begin
					queue_crc_tail();
				end else begin
					frame_open      = 1'b1;
					bytes_remaining = it.payload_length;
				end
			end
		end else if (!frame_open) begin
			queue_reject();
		end else begin
			bytes_remaining = bytes_remaining - 6'd1;
			queue_frame_byte(it.payload_byte, bytes_remaining != 0);
			if (bytes_remaining == 0) begin
				queue_crc_tail();
			end
		end
	endfunction

	// ------------------------------------------------------------------------
	// Input side
	// ------------------------------------------------------------------------

	// Presents one beat and holds it until the block takes it. Push is left high
	// so that back-to-back beats never see it dropped and raised in one step;
	// only the gap task and the drain waits lower it.
	task automatic send_beat(input in_item_t it);
		item <= it;
		push <= 1'b1;
		@(posedge clk);
		while (full) begin
			@(posedge clk);
		end
		encode_item(it);
		items_sent++;
	endtask

	// Unused fields carry random values so that the block is seen to ignore them.
	task automatic send_header(input logic [7:0] addr, input logic [7:0] func,
			input logic [5:0] len);
		in_item_t it;
		it.req_type       = REQ_HEADER;
		it.frame_address  = addr;
		it.function_code  = func;
		it.payload_length = len;
		it.payload_byte   = 8'($urandom_range(0, 255));
		send_beat(it);
	endtask

	task automatic send_payload(input logic [7:0] data);
		in_item_t it;
		it.req_type       = REQ_PAYLOAD;
		it.frame_address  = 8'($urandom_range(0, 255));
		it.function_code  = 8'($urandom_range(0, 255));
		it.payload_length = 6'($urandom_range(0, 63));
		it.payload_byte   = data;
		send_beat(it);
	endtask

	// Now and then the sender goes quiet for a burst of cycles.
	task automatic sender_gap();
		if (!quiet && $urandom_range(0, 5) == 0) begin
			push <= 1'b0;
			repeat ($urandom_range(1, 17)) @(posedge clk);
		end
	endtask

	task automatic header_then_gap(input logic [7:0] addr, input logic [7:0] func,
			input logic [5:0] len);
		send_header(addr, func, len);
		sender_gap();
	endtask

	task automatic payload_then_gap(input logic [7:0] data);
		send_payload(data);
		sender_gap();
	endtask

	// ------------------------------------------------------------------------
	// Output side
	// ------------------------------------------------------------------------

	// The receiver takes a beat most cycles but stalls in random bursts.
	always @(posedge clk) begin
		if (!arst_n) begin
			pop <= 1'b0;
		end else if (pop_hold > 0) begin
			pop <= 1'b0;
			pop_hold = pop_hold - 1;
		end else begin
			pop <= 1'b1;
			if (!quiet && $urandom_range(0, 9) == 0) begin
				pop_hold = $urandom_range(1, 17);
			end
		end
	end

	task automatic report_mismatch(input string what, input logic [7:0] got,
			input logic [7:0] want);
		$display("MISMATCH at output beat %0d: %s got %h, predicted %h",
			beats_checked, what, got, want);
		error_count++;
	endtask

	// Every beat popped is matched against the oldest prediction.
	always @(posedge clk) begin
		out_item_t want;
		if (arst_n && pop && !empty) begin
			if (frame_bytes_due.size() == 0) begin
				report_mismatch("unexpected beat, tx_byte", result.tx_byte, 8'h00);
			end else begin
				want = frame_bytes_due.pop_front();
				if (result.tx_byte !== want.tx_byte)
					report_mismatch("tx_byte", result.tx_byte, want.tx_byte);
				if (result.run_end !== want.run_end)
					report_mismatch("run_end", {7'd0, result.run_end}, {7'd0, want.run_end});
				if (result.frame_end !== want.frame_end)
					report_mismatch("frame_end", {7'd0, result.frame_end},
						{7'd0, want.frame_end});
				if (result.error !== want.error)
					report_mismatch("error", {7'd0, result.error}, {7'd0, want.error});
			end
			beats_checked++;
		end
	end

	// A hung handshake ends the run here rather than hanging the simulator.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("DONE: errors detected");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// Directed tests
	// ------------------------------------------------------------------------

	// A payload beat with no frame open is rejected.
	task automatic test_stray_payload();
		payload_then_gap(8'hFF);
	endtask

	// Zero length: the checksum follows the header within the same item.
	task automatic test_zero_length();
		header_then_gap(8'hFF, 8'h00, 6'd0);
		header_then_gap(8'h00, 8'hFF, 6'd0);
	endtask

	// Lengths just above the limit and at the top of the field are rejected.
	task automatic test_oversize_length();
		header_then_gap(8'h12, 8'h34, 6'(MAX_LEN + 1));
		header_then_gap(8'hA5, 8'h5A, 6'd63);
	endtask

	// Short frames with payload bytes at the extremes.
	task automatic test_short_frames();
		header_then_gap(8'h01, 8'h03, 6'd3);
		payload_then_gap(8'h00);
		payload_then_gap(8'hFF);
		payload_then_gap(8'h5A);
		header_then_gap(8'hAA, 8'h55, 6'd1);
		payload_then_gap(8'hA5);
	endtask

	// An oversized header inside an open frame is rejected and the frame stays open.
	task automatic test_oversize_inside_frame();
		header_then_gap(8'h7F, 8'h80, 6'd2);
		payload_then_gap(8'h11);
		header_then_gap(8'h00, 8'h00, 6'd60);
		payload_then_gap(8'h22);
	endtask

	// A new header abandons the open frame, which never gets its checksum.
	task automatic test_abandoned_frame();
		header_then_gap(8'h05, 8'h06, 6'd5);
		payload_then_gap(8'h33);
		payload_then_gap(8'h44);
		header_then_gap(8'h10, 8'h20, 6'd1);
		payload_then_gap(8'h55);
		// Abandoned by a zero-length header, which closes right away.
		header_then_gap(8'h09, 8'h08, 6'd4);
		payload_then_gap(8'h66);
		header_then_gap(8'hF0, 8'h0F, 6'd0);
		// The frame is closed now, so this byte is a stray.
		payload_then_gap(8'h77);
	endtask

	// ------------------------------------------------------------------------
	// Random tests
	// ------------------------------------------------------------------------

	// Mostly well-formed frames of random content and small length. A few are
	// long, the first one at the full limit, and now and then a frame is broken
	// by an oversized header or cut short by the next header.
	task automatic random_frame();
		logic [5:0] len;
		if (big_frames_left > 0 && $urandom_range(0, 29) == 0) begin
			len = (big_frames_left == 3) ? 6'(MAX_LEN) : 6'($urandom_range(40, MAX_LEN));
			big_frames_left--;
		end else begin
			len = 6'($urandom_range(0, 10));
		end
		header_then_gap(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), len);
		for (int n = 0; n < len; n++) begin
			if ($urandom_range(0, 59) == 0) begin
				return;
			end
			if ($urandom_range(0, 39) == 0) begin
				header_then_gap(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
					6'($urandom_range(MAX_LEN + 1, 63)));
			end
			payload_then_gap(8'($urandom_range(0, 255)));
		end
	endtask

	// Noise: stray payload bytes and oversized headers.
	task automatic random_noise();
		if ($urandom_range(0, 1) == 0) begin
			// Any frame left open by an abandoned frame is closed first.
			if (frame_open) begin
				header_then_gap(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
					6'd0);
			end
			payload_then_gap(8'($urandom_range(0, 255)));
		end else begin
			header_then_gap(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
				6'($urandom_range(MAX_LEN + 1, 63)));
		end
	endtask

	task automatic random_mix(input int count);
		int stop_at;
		stop_at = items_sent + count;
		while (items_sent < stop_at) begin
			if ($urandom_range(0, 4) == 0) begin
				random_noise();
			end else begin
				random_frame();
			end
		end
	endtask

	// The sender holds off until every predicted byte has been popped, so the
	// block runs dry and then restarts from an empty pipeline.
	task automatic test_drain_pause();
		push <= 1'b0;
		@(posedge clk);
		while (frame_bytes_due.size() != 0) begin
			@(posedge clk);
		end
		random_mix(10);
	endtask

	task automatic test_random_frames();
		random_mix(RANDOM_ITEMS / 2);
		test_drain_pause();
		random_mix(RANDOM_ITEMS / 2 - 50);
	endtask

	// Closing stretch with both sides running flat out.
	task automatic test_random_no_idle();
		quiet = 1'b1;
		random_mix(40);
	endtask

	// ------------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------------

	initial begin
		arst_n          = 1'b0;
		push            = 1'b0;
		item            = '0;
		frame_crc       = CRC_INIT;
		bytes_remaining = '0;
		frame_open      = 1'b0;
		error_count     = 0;
		items_sent      = 0;
		beats_checked   = 0;
		cycle_count     = 0;
		big_frames_left = 3;
		quiet           = 1'b0;
		pop_hold        = 0;

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_stray_payload();
		test_zero_length();
		test_oversize_length();
		test_short_frames();
		test_oversize_inside_frame();
		test_abandoned_frame();
		test_random_frames();
		test_random_no_idle();

		// All beats are in; let the output side drain, then keep watching the output
		// for any byte the block should not produce.
		push <= 1'b0;
		@(posedge clk);
		while (frame_bytes_due.size() != 0) begin
			@(posedge clk);
		end
		repeat (24) @(posedge clk);

		if (error_count == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+design
design/crc16fe_pkg.sv
design/crc16fe_front.sv
design/crc16fe_cmdq.sv
design/crc16fe_back.sv
design/crc16_frame_encoder_core.sv
sim/crc16_frame_encoder_core_test.sv
